// ===== rtl/integer_to_decimal_ascii_defines.svh =====
// Assertion macros for the decimal text converter.
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// Check cons in the same cycle as ante; reset masks the check.
`define ITDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante; reset masks the check.
`define ITDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/itda_pkg.sv =====
// Shared types, constants and width helpers for the decimal text converter.
package itda_pkg;

    localparam int DEF_VALUE_BITS = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Decimal digits of the largest unsigned value of the given width.
    // 1233/4096 approximates log10(2); exact over 1..64 bits.
    function automatic int digit_count(input int bits);
        return ((bits * 1233) >>> 12) + 1;
    endfunction

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture input, take magnitude
        logic dabble;     // one shift-and-add-3 step
        logic skip;       // drop a leading zero digit
        logic put_sign;   // load minus sign into output register
        logic put_digit;  // load top digit into output register, advance
    } t_itda_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic cnt_one;    // step or digit counter at its final count
        logic top_zero;   // most significant remaining digit is zero
        logic neg;        // item prints with a minus sign
    } t_itda_status;

endpackage

// ===== rtl/itda_datapath.sv =====
// Datapath: magnitude, double-dabble BCD register, counter and output character.
module itda_datapath
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_is_signed,
    input  t_itda_cmd             i_cmd,
    output t_itda_status          o_status,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    localparam int ND  = digit_count(VALUE_BITS);
    localparam int BW  = 4 * ND;
    localparam int CMX = (VALUE_BITS > ND) ? VALUE_BITS : ND;
    localparam int CW  = $clog2(CMX + 1);

    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BW-1:0]         r_bcd;
    logic [CW-1:0]         r_cnt;
    logic [7:0]            r_char;
    logic                  r_last;

    logic [BW-1:0]         adj;
    logic                  in_neg;
    logic                  cnt_one;

    assign in_neg  = i_is_signed & i_value[VALUE_BITS-1];
    assign cnt_one = (r_cnt == CW'(1));

    // Add 3 to every digit of 5 or more ahead of the shift.
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? (r_bcd[4*d +: 4] + 4'd3)
                                                     : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= in_neg;
            r_bin <= in_neg ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;
            r_bcd <= '0;
            r_cnt <= CW'(VALUE_BITS);
        end else if (i_cmd.dabble) begin
            r_bcd <= {adj[BW-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            // reload the counter with the digit count on the last step
            r_cnt <= cnt_one ? CW'(ND) : (r_cnt - CW'(1));
        end else if (i_cmd.skip) begin
            r_bcd <= {r_bcd[BW-5:0], 4'b0000};
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.put_digit) begin
            r_char <= CHAR_ZERO | {4'b0000, r_bcd[BW-1 -: 4]};
            r_last <= cnt_one;
            r_bcd  <= {r_bcd[BW-5:0], 4'b0000};
            r_cnt  <= r_cnt - CW'(1);
        end else if (i_cmd.put_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end
    end

    assign o_status.cnt_one  = cnt_one;
    assign o_status.top_zero = (r_bcd[BW-1 -: 4] == 4'd0);
    assign o_status.neg      = r_neg;
    assign o_character       = r_char;
    assign o_last            = r_last;

endmodule

// ===== rtl/itda_ctrl.sv =====
// Controller: sequences conversion, zero skipping and character output.
module itda_ctrl
    import itda_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  logic         i_stall,
    input  t_itda_status i_status,
    output t_itda_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   slot_free;

    assign slot_free = !r_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_valid = r_valid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_status.cnt_one) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && !i_status.cnt_one) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = i_status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.put_digit = 1'b1;
                    n_valid         = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// Top level of the binary word to decimal ASCII text converter.
//
// Input channel (i_valid / o_stall): one transfer carries i_value and
// i_is_signed. With i_is_signed high the word is two's complement.
// Output channel (o_valid / i_stall): one transfer per ASCII character,
// a minus sign for a negative signed word, then the digits most
// significant first without leading zeros; o_last marks the final one.
// Sequence: the accept loads the word, the shift-and-add-3 conversion
// steps through the input bits, then leading zero digits are dropped one
// per cycle, a decision state picks sign or digit, and the sign (for a
// negative word) and the remaining digits leave one per cycle while the
// receiver does not stall. At 32 bits there are 10 digit slots.
// One item is in work at a time; o_stall stays high from accept until the
// last character sits in the output register, so the next transfer can be
// taken while that character still waits on a stalled receiver.
// Reset (synchronous, active low) empties the output register and returns
// the controller to idle; a stalled character holds its value.
`include "integer_to_decimal_ascii_defines.svh"

module integer_to_decimal_ascii
    import itda_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_is_signed,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    t_itda_cmd    cmd;
    t_itda_status status;
    logic         char_is_minus;
    logic         char_is_digit;

    // Controller: owns the state, output valid and input stall.
    itda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: magnitude, BCD digits and the output character register.
    itda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_character (o_character),
        .o_last      (o_last)
    );

    assign char_is_minus = (o_character == CHAR_MINUS);
    assign char_is_digit = (o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE);

    // Every shown character is a digit or the minus sign.
    `ITDA_ASSERT_NOW(a_char_range, o_valid, char_is_minus || char_is_digit, "bad character")
    // A minus sign is never the final character.
    `ITDA_ASSERT_NOW(a_sign_not_last, o_valid && char_is_minus, !o_last, "minus sign marked last")
    // An accepted item blocks the input in the following cycle.
    `ITDA_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input not blocked")
    // Only one datapath command at a time.
    `ITDA_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "conflicting datapath commands")

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the decimal text converter: corner and random words, checked per character.
module tb_top;
    import itda_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_WORDS = 152;
    localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the last characters to leave
    localparam int TAIL_CYCLES  = 60;     // more than one full conversion
    localparam int RUN_LIMIT    = 6_000_000;

    // One word to convert, plus how the sender behaves around it.
    typedef struct {
        logic [31:0] value;
        logic        is_signed;
        bit          wait_drain;  // hold this word back until all text has come out
        int          phase;       // selects the idle mix on both sides
    } t_word;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_char;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [31:0] i_value     = '0;
    logic        i_is_signed = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;

    t_word pending_words[$];
    t_char expected_chars[$];

    // Idle chance in percent per phase: sender light / receiver heavy, then swapped, then none.
    int    tx_idle_pct[3] = '{37, 75, 0};
    int    rx_idle_pct[3] = '{75, 37, 0};
    int    idle_phase     = 0;

    bit    word_taken     = 1'b0;
    int    words_taken    = 0;
    int    negatives      = 0;
    int    chars_checked  = 0;
    int    mismatches     = 0;

    integer_to_decimal_ascii #(
        .VALUE_BITS (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Append the decimal text of one word: optional minus sign, then the
    // digits most significant first, last mark on the final digit.
    task automatic predict_decimal_text(input logic [31:0] value, input logic is_signed);
        logic [31:0] mag;
        logic [3:0]  digits [10];
        int          nd;
        bit          neg;
        neg = is_signed && value[31];
        // Two's complement negate; the most negative word maps onto 2^31 itself.
        mag = neg ? (~value + 32'd1) : value;
        nd = 0;
        do begin
            digits[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
        end while (mag != 0);
        if (neg) begin
            expected_chars.push_back(t_char'{CHAR_MINUS, 1'b0});
            negatives++;
        end
        for (int i = nd - 1; i >= 0; i--)
            expected_chars.push_back(t_char'{CHAR_ZERO + 8'(digits[i]), (i == 0)});
    endtask

    task automatic add_word(input logic [31:0] value, input logic is_signed,
                            input bit wait_drain, input int phase);
        pending_words.push_back(t_word'{value, is_signed, wait_drain, phase});
    endtask

    // Sample both channels at the rising edge: check characters, predict accepted words.
    always @(posedge i_clk) begin
        t_char exp_c;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 8'h%02h last %b",
                                              o_character, o_last));
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (o_character !== exp_c.character)
                        report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                                  o_character, exp_c.character));
                    if (o_last !== exp_c.last)
                        report_mismatch($sformatf("last %b on character 8'h%02h, expected %b",
                                                  o_last, exp_c.character, exp_c.last));
                    chars_checked++;
                end
            end
            if (i_valid && !o_stall) begin
                predict_decimal_text(i_value, i_is_signed);
                words_taken++;
            end
            word_taken <= i_valid && !o_stall;
        end else begin
            word_taken <= 1'b0;
        end
    end

    // Sender: hold a word until its transfer, then offer the next one or idle.
    always @(negedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            if (pending_words.size() == 0
                    || (pending_words[0].wait_drain && expected_chars.size() != 0)
                    || $urandom_range(99) < tx_idle_pct[pending_words[0].phase]) begin
                i_valid <= 1'b0;
            end else begin
                w = pending_words.pop_front();
                i_valid     <= 1'b1;
                i_value     <= w.value;
                i_is_signed <= w.is_signed;
                idle_phase  <= w.phase;
            end
        end
    end

    // Receiver: stall at random according to the current phase.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < rx_idle_pct[idle_phase]);
    end

    initial begin
        logic [31:0] value;
        logic [31:0] pow10;
        logic        sgn;
        int          phase;
        int          waited;

        // Directed words: zero, single digits, powers of ten, both extremes of
        // each reading, and the most negative word read as signed.
        add_word(32'd0,          1'b0, 1'b0, 0);
        add_word(32'd0,          1'b1, 1'b0, 0);
        add_word(32'd1,          1'b0, 1'b0, 0);
        add_word(32'd9,          1'b1, 1'b0, 0);
        add_word(32'd10,         1'b0, 1'b0, 0);
        add_word(32'd100,        1'b1, 1'b0, 0);
        add_word(32'd999999999,  1'b0, 1'b0, 0);
        add_word(32'd1000000000, 1'b1, 1'b0, 0);
        add_word(32'hFFFF_FFFF,  1'b0, 1'b0, 0);
        add_word(32'hFFFF_FFFF,  1'b1, 1'b0, 0);
        add_word(32'h8000_0000,  1'b1, 1'b0, 0);
        add_word(32'h8000_0000,  1'b0, 1'b0, 0);
        add_word(32'h7FFF_FFFF,  1'b1, 1'b0, 0);
        add_word(32'h7FFF_FFFF,  1'b0, 1'b0, 0);
        add_word(32'h8000_0001,  1'b1, 1'b0, 0);
        add_word(-32'sd10,       1'b1, 1'b0, 0);
        add_word(32'hAAAA_5555,  1'b0, 1'b0, 0);
        add_word(32'h5555_AAAA,  1'b1, 1'b0, 0);

        // Random words in three idle phases; a few wait for the output to drain.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            phase = n * 3 / RANDOM_WORDS;
            sgn = 1'($urandom_range(1));
            case ($urandom_range(5))
                0: value = $urandom;
                1: value = $urandom_range(99);
                2: begin
                    pow10 = 32'd1;
                    repeat ($urandom_range(9)) pow10 = pow10 * 32'd10;
                    value = pow10 + $urandom_range(2) - 32'd1;
                end
                3: begin
                    value = -$urandom_range(1000, 1);
                    sgn = 1'b1;
                end
                4: value = $urandom >> $urandom_range(31);
                default: begin
                    case ($urandom_range(2))
                        0: value = 32'h8000_0000;
                        1: value = 32'h7FFF_FFFF;
                        default: value = 32'hFFFF_FFFF;
                    endcase
                    value = value + $urandom_range(2) - 32'd1;
                end
            endcase
            add_word(value, sgn, (n % 57 == 0) || (n == 100), phase);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is transferred (sender signals change on the falling edge).
        do @(posedge i_clk); while (pending_words.size() != 0 || i_valid);

        // Let the remaining characters out (the check queue changes on the rising edge).
        waited = 0;
        while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));

        $display("Converted %0d words (%0d printed with a minus sign), %0d characters checked,",
                 words_taken, negatives, chars_checked);
        $display("under sender-heavy, receiver-heavy and free-running idle mixes.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("TIMEOUT at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/itda_pkg.sv
rtl/itda_datapath.sv
rtl/itda_ctrl.sv
rtl/integer_to_decimal_ascii.sv
tb/sv/tb_top.sv
